// File: rtl/atca_pkg.sv
// Package for the tile collision accumulator: default widths, fixed-point
// constants, configuration register indexes and the shared evaluation flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atca_pkg;

    // Default field widths.
    localparam int KIND_BITS_DEF  = 8;
    localparam int COORD_BITS_DEF = 24;

    // Q.8 constants: one unit of horizontal shrink and the side margin of 50.
    localparam int SHRINK_Q8 = 256;
    localparam int MARGIN_Q8 = 12800;

    // Guard bits added to the coordinate width for internal sums.
    localparam int GUARD_BITS = 6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENTITY_LEFT   = 2'd0;
    localparam logic [1:0] CFG_ENTITY_TOP    = 2'd1;
    localparam logic [1:0] CFG_ENTITY_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_ENTITY_HEIGHT = 2'd3;

    // Side bit positions in the side mask.
    localparam int SIDE_LEFT  = 0;
    localparam int SIDE_RIGHT = 1;
    localparam int SIDE_UP    = 2;
    localparam int SIDE_DOWN  = 3;

    // Result of evaluating one tile against the entity box.
    typedef struct packed {
        logic       hit;
        logic [3:0] side;
    } t_eval_flags;

endpackage : atca_pkg

`default_nettype wire

// File: rtl/atca_tile_eval.sv
// Per-tile evaluation: intersection test, side selection and overlap value.
// Purely combinational; depends on atca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atca_tile_eval
    import atca_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0]          i_entity_left,
    input  wire logic signed [COORD_BITS-1:0]          i_entity_top,
    input  wire logic        [COORD_BITS-2:0]          i_entity_width,
    input  wire logic        [COORD_BITS-2:0]          i_entity_height,
    input  wire logic signed [COORD_BITS-1:0]          i_tile_left,
    input  wire logic signed [COORD_BITS-1:0]          i_tile_top,
    input  wire logic        [COORD_BITS-2:0]          i_tile_width,
    input  wire logic        [COORD_BITS-2:0]          i_tile_height,
    input  wire logic                                  i_tile_solid,
    output t_eval_flags                                o_flags,
    output logic signed [COORD_BITS+GUARD_BITS-1:0]    o_overlap
);

    localparam int W = COORD_BITS + GUARD_BITS;

    logic signed [W-1:0] el, et, er, eb;
    logic signed [W-1:0] tl, tt, tr, tb;
    logic signed [W-1:0] sa, sb, sx0, sx1;
    logic signed [W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [W-1:0] ov_l, ov_r, ov_u, ov_d;
    logic signed [W-1:0] h_ovl, v_ovl;
    logic                hit;
    logic [3:0]          side;

    // Widen all edges to the internal width.
    assign el = {{(W-COORD_BITS){i_entity_left[COORD_BITS-1]}}, i_entity_left};
    assign et = {{(W-COORD_BITS){i_entity_top[COORD_BITS-1]}}, i_entity_top};
    assign er = el + {{(W-COORD_BITS+1){1'b0}}, i_entity_width};
    assign eb = et + {{(W-COORD_BITS+1){1'b0}}, i_entity_height};
    assign tl = {{(W-COORD_BITS){i_tile_left[COORD_BITS-1]}}, i_tile_left};
    assign tt = {{(W-COORD_BITS){i_tile_top[COORD_BITS-1]}}, i_tile_top};
    assign tr = tl + {{(W-COORD_BITS+1){1'b0}}, i_tile_width};
    assign tb = tt + {{(W-COORD_BITS+1){1'b0}}, i_tile_height};

    // Shrunk horizontal span of the tile, with edges ordered for narrow tiles.
    assign sa  = tl + W'(SHRINK_Q8);
    assign sb  = tr - W'(SHRINK_Q8);
    assign sx0 = (sa < sb) ? sa : sb;
    assign sx1 = (sa > sb) ? sa : sb;

    // Strict intersection on both axes; empty boxes fall out naturally.
    assign x_lo = (el > sx0) ? el : sx0;
    assign x_hi = (er < sx1) ? er : sx1;
    assign y_lo = (et > tt) ? et : tt;
    assign y_hi = (eb < tb) ? eb : tb;
    assign hit  = i_tile_solid && (x_lo < x_hi) && (y_lo < y_hi);

    // Candidate overlaps for side selection.
    assign ov_l = tr - el + W'(MARGIN_Q8);
    assign ov_r = er - tl + W'(MARGIN_Q8);
    assign ov_u = tb - et;
    assign ov_d = eb - tt;

    // Largest overlap wins; ties go to the earlier side in left, right, up, down.
    always_comb begin
        side = '0;
        if ((ov_l >= ov_r) && (ov_l >= ov_u) && (ov_l >= ov_d)) begin
            side[SIDE_LEFT] = 1'b1;
        end else if ((ov_r >= ov_u) && (ov_r >= ov_d)) begin
            side[SIDE_RIGHT] = 1'b1;
        end else if (ov_u >= ov_d) begin
            side[SIDE_UP] = 1'b1;
        end else begin
            side[SIDE_DOWN] = 1'b1;
        end
    end

    // Vertical overlap when up is chosen, else horizontal; edge-order rule.
    assign h_ovl = (el < tl) ? (er - tl) : (tr - el);
    assign v_ovl = (et < tt) ? (eb - tt) : (tb - et);

    assign o_flags.hit  = hit;
    assign o_flags.side = side;
    assign o_overlap    = side[SIDE_UP] ? v_ovl : h_ovl;

endmodule : atca_tile_eval

`default_nettype wire

// File: rtl/aabb_tile_collision_accumulator.sv
// Top level of the tile collision accumulator: configuration registers, input
// stage, accumulators and result register. Depends on atca_pkg and atca_tile_eval.
//
// Usage: write the entity box through the configuration channel (index 0 left,
// 1 top, 2 width, 3 height) while no pass is in flight; the port is always ready.
// Then stream tile beats on the input channel, one per cycle if desired. Each
// beat is registered, evaluated against the entity box from that register and
// folded into the running side, kind and minimum-overlap totals. A beat with
// last_tile set emits one result beat holding the totals including that tile,
// and the totals are cleared for the next pass.
// Throughput: one tile per cycle while no last tile is held back. A result beat
// passes through the input register, then the result register. When the
// receiver stalls, the result waits in the output register; tiles that are not
// last keep flowing, and a further last tile holds in the input register until
// the output register frees. Reset clears the entity box to zero, the totals to
// zero and the overlap minimums to the none value, and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module aabb_tile_collision_accumulator
    import atca_pkg::*;
#(
    parameter int KIND_BITS  = KIND_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write channel.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [COORD_BITS-1:0]        i_cfg_data,
    // Tile input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [COORD_BITS-1:0] i_tile_left,
    input  wire logic signed [COORD_BITS-1:0] i_tile_top,
    input  wire logic [COORD_BITS-2:0]        i_tile_width,
    input  wire logic [COORD_BITS-2:0]        i_tile_height,
    input  wire logic                         i_tile_solid,
    input  wire logic [KIND_BITS-1:0]         i_tile_kind_bits,
    input  wire logic                         i_last_tile,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [KIND_BITS-1:0]              o_hit_kinds,
    output logic [3:0]                        o_hit_sides,
    output logic signed [COORD_BITS+1:0]      o_min_horizontal_overlap,
    output logic signed [COORD_BITS+1:0]      o_min_vertical_overlap
);

    localparam int W  = COORD_BITS + GUARD_BITS;
    localparam int OW = COORD_BITS + 2;
    localparam logic signed [OW-1:0] OVL_NONE = {1'b0, {(OW-1){1'b1}}};

    // Configuration registers.
    logic signed [COORD_BITS-1:0] r_entity_left, r_entity_top;
    logic [COORD_BITS-2:0]        r_entity_width, r_entity_height;

    // Input stage.
    logic                         r_s1_valid;
    logic signed [COORD_BITS-1:0] r_tile_left, r_tile_top;
    logic [COORD_BITS-2:0]        r_tile_width, r_tile_height;
    logic                         r_tile_solid;
    logic [KIND_BITS-1:0]         r_tile_kind_bits;
    logic                         r_last_tile;

    // Running totals.
    logic [3:0]           r_side_accum, n_side_accum;
    logic [KIND_BITS-1:0] r_kind_accum, n_kind_accum;
    logic signed [OW-1:0] r_min_horiz, n_min_horiz;
    logic signed [OW-1:0] r_min_vert, n_min_vert;

    // Result register.
    logic                 r_out_valid;
    logic [KIND_BITS-1:0] r_hit_kinds;
    logic [3:0]           r_hit_sides;
    logic signed [OW-1:0] r_min_h_out, r_min_v_out;

    t_eval_flags          eval_flags;
    logic signed [W-1:0]  eval_overlap;
    logic signed [W-1:0]  min_h_wide, min_v_wide;
    logic                 out_free, s1_advance, emit;

    // Configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entity_left   <= '0;
            r_entity_top    <= '0;
            r_entity_width  <= '0;
            r_entity_height <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENTITY_LEFT:   r_entity_left   <= i_cfg_data;
                CFG_ENTITY_TOP:    r_entity_top    <= i_cfg_data;
                CFG_ENTITY_WIDTH:  r_entity_width  <= i_cfg_data[COORD_BITS-2:0];
                CFG_ENTITY_HEIGHT: r_entity_height <= i_cfg_data[COORD_BITS-2:0];
                default:           ;
            endcase
        end
    end

    // Handshake: a last tile needs a free result register to move on.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_advance = r_s1_valid && (!r_last_tile || out_free);
    assign emit       = s1_advance && r_last_tile;
    assign o_in_ready = !r_s1_valid || s1_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tile_left      <= i_tile_left;
            r_tile_top       <= i_tile_top;
            r_tile_width     <= i_tile_width;
            r_tile_height    <= i_tile_height;
            r_tile_solid     <= i_tile_solid;
            r_tile_kind_bits <= i_tile_kind_bits;
            r_last_tile      <= i_last_tile;
        end
    end

    atca_tile_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_entity_left   (r_entity_left),
        .i_entity_top    (r_entity_top),
        .i_entity_width  (r_entity_width),
        .i_entity_height (r_entity_height),
        .i_tile_left     (r_tile_left),
        .i_tile_top      (r_tile_top),
        .i_tile_width    (r_tile_width),
        .i_tile_height   (r_tile_height),
        .i_tile_solid    (r_tile_solid),
        .o_flags         (eval_flags),
        .o_overlap       (eval_overlap)
    );

    assign min_h_wide = {{(W-OW){r_min_horiz[OW-1]}}, r_min_horiz};
    assign min_v_wide = {{(W-OW){r_min_vert[OW-1]}}, r_min_vert};

    // Fold the evaluated tile into the totals.
    always_comb begin
        n_side_accum = r_side_accum;
        n_kind_accum = r_kind_accum;
        n_min_horiz  = r_min_horiz;
        n_min_vert   = r_min_vert;
        if (eval_flags.hit) begin
            n_side_accum = r_side_accum | eval_flags.side;
            n_kind_accum = r_kind_accum | r_tile_kind_bits;
            if (eval_flags.side[SIDE_UP]) begin
                if (eval_overlap < min_v_wide) begin
                    n_min_vert = eval_overlap[OW-1:0];
                end
            end else begin
                if (eval_overlap < min_h_wide) begin
                    n_min_horiz = eval_overlap[OW-1:0];
                end
            end
        end
    end

    // Totals update; a last tile clears them as its result is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_accum <= '0;
            r_kind_accum <= '0;
            r_min_horiz  <= OVL_NONE;
            r_min_vert   <= OVL_NONE;
        end else if (emit) begin
            r_side_accum <= '0;
            r_kind_accum <= '0;
            r_min_horiz  <= OVL_NONE;
            r_min_vert   <= OVL_NONE;
        end else if (s1_advance) begin
            r_side_accum <= n_side_accum;
            r_kind_accum <= n_kind_accum;
            r_min_horiz  <= n_min_horiz;
            r_min_vert   <= n_min_vert;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hit_kinds <= n_kind_accum;
            r_hit_sides <= n_side_accum;
            r_min_h_out <= n_min_horiz;
            r_min_v_out <= n_min_vert;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_hit_kinds              = r_hit_kinds;
    assign o_hit_sides              = r_hit_sides;
    assign o_min_horizontal_overlap = r_min_h_out;
    assign o_min_vertical_overlap   = r_min_v_out;

endmodule : aabb_tile_collision_accumulator

`default_nettype wire
